// ----- design/set_of_stacks_with_pop_at_defines.svh -----
// Assertion macros used by the set-of-stacks top design file.
`ifndef SET_OF_STACKS_WITH_POP_AT_DEFINES_SVH
`define SET_OF_STACKS_WITH_POP_AT_DEFINES_SVH

// Check cons in the same cycle whenever ante holds.
`define SOSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define SOSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sosp_pkg.sv -----
package sosp_pkg;

  // Default geometry of the stack set
  localparam int unsigned SubDepthDef  = 16;
  localparam int unsigned NumSubDef    = 8;
  localparam int unsigned DataWidthDef = 32;

  typedef enum logic [1:0] {
    ACT_PUSH,
    ACT_POP,
    ACT_TOP,
    ACT_POP_AT
  } action_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_RANGE
  } status_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] push_value;
    logic [2:0]         sub_index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    status_e            status;
  } rsp_t;

endpackage

// ----- design/sosp_store.sv -----
module sosp_store #(
  parameter int unsigned Depth = 128,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Single-port array, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/set_of_stacks_with_pop_at.sv -----
// A request's result passes through the read stage (store read) and then the output register.
// Throughput: one request per cycle while in_stall_o is low; the store is touched at most once per request and
// the target sub-stack's fill count and non-empty flag update in the accept cycle.
// Input stalls only while a result waits in the read stage and the output register is blocked.
// Reset: asynchronous, active low; clears fill counts, flags and the current index at once.
// Entry store contents are not reset; no clearing pass is needed.
`include "set_of_stacks_with_pop_at_defines.svh"

module set_of_stacks_with_pop_at #(
  parameter int unsigned SUB_DEPTH  = sosp_pkg::SubDepthDef,
  parameter int unsigned NUM_SUB    = sosp_pkg::NumSubDef,
  parameter int unsigned DATA_WIDTH = sosp_pkg::DataWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sosp_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sosp_pkg::rsp_t out_rsp_o
);
  import sosp_pkg::*;

  localparam int unsigned SubW    = (NUM_SUB > 1) ? $clog2(NUM_SUB) : 1;
  localparam int unsigned CntW    = $clog2(SUB_DEPTH + 1);
  localparam int unsigned Entries = NUM_SUB * SUB_DEPTH;
  localparam int unsigned AddrW   = (Entries > 1) ? $clog2(Entries) : 1;

  logic [SubW-1:0]    cur_q, cur_d;
  logic [NUM_SUB-1:0] nonempty_q, nonempty_d;
  logic [CntW-1:0]    fill_q [NUM_SUB];
  logic [CntW-1:0]    fill_d [NUM_SUB];

  logic               pend_q;
  logic               pend_top_q;
  status_e            pend_status_q;
  logic               out_valid_q;
  rsp_t               out_q;

  logic               accept;
  logic               move;
  logic [NUM_SUB-1:0] full_vec;
  logic               walk_hit, find_hit;
  logic [SubW-1:0]    walk_sub, find_sub;
  logic               cur_full, at_last;
  logic [SubW-1:0]    nxt_sub;
  logic [SubW-1:0]    tgt;
  status_e            acc_status;
  logic [CntW-1:0]    tgt_fill, pos_dec;
  logic [AddrW-1:0]   base_addr, mem_addr;
  logic               mem_we, mem_re;
  logic signed [63:0] push_wide;
  logic [DATA_WIDTH-1:0] rd_data;
  logic signed [63:0] top_wide;

  assign accept     = in_valid_i & ~in_stall_o;
  assign move       = pend_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = pend_q & out_valid_q & out_stall_i;

  // Per-sub-stack full flags
  always_comb begin
    for (int j = 0; j < NUM_SUB; j++) begin
      full_vec[j] = (fill_q[j] == CntW'(SUB_DEPTH));
    end
  end

  // Priority find: highest non-empty sub-stack at or below the current / named index
  always_comb begin
    walk_hit = 1'b0;
    walk_sub = '0;
    find_hit = 1'b0;
    find_sub = '0;
    for (int j = 0; j < NUM_SUB; j++) begin
      if (nonempty_q[j] && (j <= int'(cur_q))) begin
        walk_hit = 1'b1;
        walk_sub = SubW'(j);
      end
      if (nonempty_q[j] && (j <= int'(in_req_i.sub_index))) begin
        find_hit = 1'b1;
        find_sub = SubW'(j);
      end
    end
  end

  assign cur_full = full_vec[cur_q];
  assign at_last  = (cur_q == SubW'(NUM_SUB - 1));
  assign nxt_sub  = cur_q + SubW'(1);

  // Decide target sub-stack, status and new current index
  always_comb begin
    tgt        = cur_q;
    acc_status = ST_OK;
    cur_d      = cur_q;
    unique case (in_req_i.action)
      ACT_PUSH: begin
        if (cur_full && at_last) begin
          acc_status = ST_FULL;
        end else begin
          tgt = cur_full ? nxt_sub : cur_q;
          if (full_vec[tgt]) begin
            acc_status = ST_FULL;
          end else begin
            cur_d = tgt;
          end
        end
      end
      ACT_POP, ACT_TOP: begin
        cur_d = walk_hit ? walk_sub : '0;
        tgt   = walk_sub;
        if (!walk_hit) begin
          acc_status = ST_EMPTY;
        end
      end
      ACT_POP_AT: begin
        cur_d = walk_hit ? walk_sub : '0;
        tgt   = find_sub;
        if (!walk_hit) begin
          acc_status = ST_EMPTY;
        end else if (int'(in_req_i.sub_index) >= int'(NUM_SUB)) begin
          acc_status = ST_RANGE;
        end else if (!find_hit) begin
          acc_status = ST_EMPTY;
        end
      end
      default: begin
        acc_status = ST_OK;
      end
    endcase
  end

  assign tgt_fill  = fill_q[tgt];
  assign pos_dec   = tgt_fill - CntW'(1);
  assign base_addr = AddrW'(32'(tgt) * SUB_DEPTH);
  assign mem_addr  = base_addr +
                     ((in_req_i.action == ACT_PUSH) ? AddrW'(tgt_fill) : AddrW'(pos_dec));
  assign mem_we    = accept && (acc_status == ST_OK) && (in_req_i.action == ACT_PUSH);
  assign mem_re    = accept && (acc_status == ST_OK) && (in_req_i.action == ACT_TOP);
  assign push_wide = 64'(in_req_i.push_value);

  // Update fill counts and non-empty flags
  always_comb begin
    fill_d     = fill_q;
    nonempty_d = nonempty_q;
    if (accept && (acc_status == ST_OK)) begin
      unique case (in_req_i.action)
        ACT_PUSH: begin
          fill_d[tgt]     = tgt_fill + CntW'(1);
          nonempty_d[tgt] = 1'b1;
        end
        ACT_POP, ACT_POP_AT: begin
          fill_d[tgt]     = pos_dec;
          nonempty_d[tgt] = (pos_dec != '0);
        end
        default: begin
          fill_d[tgt] = tgt_fill;
        end
      endcase
    end
  end

  sosp_store #(
    .Depth(Entries),
    .Width(DATA_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .rd_en_i  (mem_re),
    .addr_i   (mem_addr),
    .wr_data_i(push_wide[DATA_WIDTH-1:0]),
    .rd_data_o(rd_data)
  );

  assign top_wide = 64'(signed'(rd_data));

  // Hold stack state; advance the read stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      nonempty_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NUM_SUB; j++) begin
        fill_q[j] <= '0;
      end
    end else begin
      if (accept) begin
        cur_q      <= cur_d;
        nonempty_q <= nonempty_d;
        fill_q     <= fill_d;
      end
      if (accept) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers of the pipeline stages
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_top_q    <= (in_req_i.action == ACT_TOP) && (acc_status == ST_OK);
      pend_status_q <= acc_status;
    end
    if (move) begin
      out_q.top_value <= pend_top_q ? top_wide[31:0] : '0;
      out_q.status    <= pend_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SOSP_ASSERT_NOW(a_top_only_ok, out_valid_o, (out_rsp_o.status == ST_OK) || (out_rsp_o.top_value == '0), "nonzero top value on a failed request")
  `SOSP_ASSERT_NOW(a_cur_range, 1'b1, int'(cur_q) < int'(NUM_SUB), "current sub-stack index out of range")
  `SOSP_ASSERT_NEXT(a_push_nonempty, accept && (in_req_i.action == ACT_PUSH) && (acc_status == ST_OK), nonempty_q[cur_q], "current sub-stack empty after a good push")
  `SOSP_ASSERT_NEXT(a_pend_hold, pend_q && out_valid_o && out_stall_i, pend_q, "pending result dropped under stall")
  `SOSP_ASSERT_NOW(a_stall_cause, in_stall_o, pend_q && out_valid_o, "input stalled with no blocked result")

endmodule

// ----- bench/set_of_stacks_with_pop_at_test.sv -----
module set_of_stacks_with_pop_at_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sosp_pkg::*;

  localparam int unsigned NUM_SUB        = NumSubDef;
  localparam int unsigned SUB_DEPTH      = SubDepthDef;
  localparam int unsigned TOTAL_ENTRIES  = NUM_SUB * SUB_DEPTH;
  localparam int unsigned HOLDOFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_BATCHES = 12;
  localparam int unsigned BATCH_LEN      = 135;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  idle_mode_e  idle_mode    = IDLE_NONE;
  logic        holdoff_go   = 1'b0;
  int unsigned holdoff_left = 0;

  // Shadow of the stack set
  logic signed [31:0] stack_entries [NUM_SUB][SUB_DEPTH];
  int unsigned        fill_level    [NUM_SUB];
  int unsigned        cur_sub;

  rsp_t        pending_rsp_q[$];
  int unsigned mismatch_count = 0;
  int unsigned accepted_count = 0;
  int unsigned ok_count       = 0;
  int unsigned full_count     = 0;
  int unsigned empty_count    = 0;

  set_of_stacks_with_pop_at u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Walk the current sub-stack down past empty ones; report whether the set is empty
  function automatic bit settle_current();
    while (cur_sub > 0 && fill_level[cur_sub] == 0) cur_sub--;
    return fill_level[cur_sub] == 0;
  endfunction

  // Apply one request to the shadow and return the response it must produce
  function automatic rsp_t stack_response(input req_t req);
    rsp_t        rsp;
    int unsigned s;
    rsp.top_value = '0;
    rsp.status    = ST_OK;
    case (req.action)
      ACT_PUSH: begin
        s = cur_sub;
        if (fill_level[s] >= SUB_DEPTH) begin
          if (s + 1 >= NUM_SUB) rsp.status = ST_FULL;
          else s++;
        end
        if (rsp.status == ST_OK) begin
          if (fill_level[s] >= SUB_DEPTH) begin
            rsp.status = ST_FULL;
          end else begin
            cur_sub = s;
            stack_entries[s][fill_level[s]] = req.push_value;
            fill_level[s]++;
          end
        end
      end
      ACT_POP, ACT_TOP: begin
        if (settle_current()) begin
          rsp.status = ST_EMPTY;
        end else if (req.action == ACT_TOP) begin
          rsp.top_value = stack_entries[cur_sub][fill_level[cur_sub] - 1];
        end else begin
          fill_level[cur_sub]--;
        end
      end
      default: begin
        if (settle_current()) begin
          rsp.status = ST_EMPTY;
        end else if (req.sub_index >= NUM_SUB) begin
          rsp.status = ST_RANGE;
        end else begin
          s = 32'(req.sub_index);
          while (s > 0 && fill_level[s] == 0) s--;
          if (fill_level[s] == 0) rsp.status = ST_EMPTY;
          else fill_level[s]--;
        end
      end
    endcase
    return rsp;
  endfunction

  // Build a request with random content; push_pct biases toward filling or draining
  function automatic req_t random_request(input int unsigned push_pct);
    req_t req;
    req.push_value = $urandom();
    case ($urandom_range(15))
      0: req.push_value = 32'h7FFF_FFFF;
      1: req.push_value = 32'h8000_0000;
      2: req.push_value = '0;
      3: req.push_value = '1;
      default: ;
    endcase
    req.sub_index = 3'($urandom_range(7));
    if ($urandom_range(99) < push_pct) begin
      req.action = ACT_PUSH;
    end else begin
      case ($urandom_range(2))
        0: req.action = ACT_POP;
        1: req.action = ACT_TOP;
        default: req.action = ACT_POP_AT;
      endcase
    end
    return req;
  endfunction

  // Offer one request, wait for the handshake, record its expected response
  task automatic send_request(input req_t req);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rsp_q.push_back(stack_response(req));
    accepted_count++;
  endtask

  // Drop valid and hold until every expected response has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, every action, empty cases and pop-at walking down
  task automatic test_edge_values();
    idle_mode = IDLE_NONE;
    send_request(req_t'{ACT_TOP,    32'sh0000_0000, 3'd0});
    send_request(req_t'{ACT_POP,    32'sh0000_0000, 3'd7});
    send_request(req_t'{ACT_POP_AT, 32'sh0000_0000, 3'd7});
    send_request(req_t'{ACT_PUSH,   32'sh7FFF_FFFF, 3'd7});
    send_request(req_t'{ACT_PUSH,   32'sh8000_0000, 3'd0});
    send_request(req_t'{ACT_TOP,    32'sh7FFF_FFFF, 3'd5});
    send_request(req_t'{ACT_PUSH,   32'sh0000_0000, 3'd2});
    send_request(req_t'{ACT_PUSH,   32'shFFFF_FFFF, 3'd7});
    send_request(req_t'{ACT_TOP,    32'shFFFF_FFFF, 3'd7});
    send_request(req_t'{ACT_POP_AT, 32'sh0000_0000, 3'd5});
    send_request(req_t'{ACT_TOP,    32'sh0000_0000, 3'd0});
    send_request(req_t'{ACT_POP,    32'shFFFF_FFFF, 3'd0});
    send_request(req_t'{ACT_POP_AT, 32'sh0000_0000, 3'd0});
    send_request(req_t'{ACT_TOP,    32'sh8000_0000, 3'd0});
    send_request(req_t'{ACT_POP,    32'sh0000_0000, 3'd0});
    send_request(req_t'{ACT_POP,    32'sh0000_0000, 3'd0});
  endtask

  // Fill every sub-stack past full, empty the bottom one by pop-at, then drain
  task automatic test_fill_and_drain();
    req_t req;
    idle_mode = IDLE_BOTH;
    repeat (TOTAL_ENTRIES + 2) send_request(random_request(100));
    req = random_request(0);
    req.action = ACT_TOP;
    send_request(req);
    req.action    = ACT_POP_AT;
    req.sub_index = '0;
    repeat (SUB_DEPTH + 1) send_request(req);
    req.sub_index = '1;
    send_request(req);
    req.action = ACT_POP;
    repeat (TOTAL_ENTRIES) send_request(req);
  endtask

  // Hold the output off for a long stretch while requests keep coming
  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    holdoff_go <= 1'b1;
    @(posedge clk_i);
    holdoff_go <= 1'b0;
    repeat (40) send_request(random_request(50));
  endtask

  // Random batches cycling through idle modes and push bias
  task automatic test_random_mix();
    int unsigned push_bias [6] = '{90, 25, 60, 45, 95, 10};
    for (int unsigned b = 0; b < RANDOM_BATCHES; b++) begin
      idle_mode = idle_mode_e'(b % 4);
      repeat (BATCH_LEN) send_request(random_request(push_bias[b % 6]));
    end
  endtask

  // Count down the long output hold-off
  always @(posedge clk_i) begin
    if (holdoff_go) holdoff_left <= HOLDOFF_CYCLES;
    else if (holdoff_left != 0) holdoff_left <= holdoff_left - 1;
  end

  // Stall the output at random per idle mode, or solidly during a hold-off
  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) <
                     ((idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 11 : 0);
    end
  end

  // Compare each accepted response with the oldest expectation
  always @(posedge clk_i) begin : check_responses
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] response with nothing pending: top_value %0d status %0d",
                   $realtime, out_rsp_o.top_value, out_rsp_o.status);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_rsp_o.top_value !== want.top_value || out_rsp_o.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: expected top_value %0d status %0d, got %0d status %0d",
                     $realtime, want.top_value, want.status,
                     out_rsp_o.top_value, out_rsp_o.status);
        end
        case (want.status)
          ST_OK:    ok_count++;
          ST_FULL:  full_count++;
          ST_EMPTY: empty_count++;
          default: ;
        endcase
      end
    end
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("set_of_stacks_with_pop_at verification failed");
    $finish;
  end

  initial begin
    cur_sub = 0;
    foreach (fill_level[i]) fill_level[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_values();
    wait_for_drain();
    test_fill_and_drain();
    wait_for_drain();
    test_backpressure();
    wait_for_drain();
    test_random_mix();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests across all idle modes, a long output hold-off and full fills;",
             accepted_count);
    $display("responses: %0d ok, %0d all-full, %0d empty; %0d mismatches.",
             ok_count, full_count, empty_count, mismatch_count);
    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("set_of_stacks_with_pop_at verification clean");
    end else begin
      $display("set_of_stacks_with_pop_at verification failed");
    end
    $finish;
  end

endmodule
